/* hw/rtl/pngu_pkg.sv */
// shared types and constants for the png scanline unfilter
`timescale 1ns / 1ps
`default_nettype none

package pngu_pkg;

    localparam int BYTE_W      = 8;
    localparam int FILT_TYPE_W = 3;
    localparam int BPP_W       = 4;
    localparam int ROW_BYTES_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int WIN_DEPTH   = 8;
    localparam int WIN_IDX_W   = 3;

    // filter types
    localparam logic [FILT_TYPE_W-1:0] FT_NONE    = 3'd0;
    localparam logic [FILT_TYPE_W-1:0] FT_SUB     = 3'd1;
    localparam logic [FILT_TYPE_W-1:0] FT_UP      = 3'd2;
    localparam logic [FILT_TYPE_W-1:0] FT_AVERAGE = 3'd3;
    localparam logic [FILT_TYPE_W-1:0] FT_PAETH   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'd1;

    typedef logic [BYTE_W-1:0] byte_t;

    // neighbours of the byte being reconstructed
    typedef struct packed {
        byte_t left;      // a: raw byte one pixel to the left
        byte_t up;        // b: prior row byte, same column
        byte_t up_left;   // c: prior row byte one pixel to the left
    } nbr_t;

endpackage

`default_nettype wire

/* hw/rtl/pngu_if.sv */
// valid/ready channel interfaces for filtered and reconstructed bytes
`timescale 1ns / 1ps
`default_nettype none

interface pngu_in_if;
    import pngu_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [BYTE_W-1:0]      filt_byte;
    logic [FILT_TYPE_W-1:0] filter_type;
    logic                   first_row;

    modport source (output valid, output filt_byte, output filter_type, output first_row,
                    input ready);
    modport sink   (input valid, input filt_byte, input filter_type, input first_row,
                    output ready);
endinterface

interface pngu_out_if;
    import pngu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] raw_byte;
    logic              row_end;

    modport source (output valid, output raw_byte, output row_end, input ready);
    modport sink   (input valid, input raw_byte, input row_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pngu_prior_ram.sv */
// prior row memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module pngu_prior_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire                       clk,
    input  wire                       wr_en,
    input  wire  [AW-1:0]             wr_addr,
    input  wire  pngu_pkg::byte_t     wr_data,
    input  wire                       rd_en,
    input  wire  [AW-1:0]             rd_addr,
    output pngu_pkg::byte_t           rd_data
);
    import pngu_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/pngu_predictor.sv */
// filter predictor and byte reconstruction
`timescale 1ns / 1ps
`default_nettype none

module pngu_predictor (
    input  wire  pngu_pkg::byte_t                    filt_byte,
    input  wire  [pngu_pkg::FILT_TYPE_W-1:0]         filter_type,
    input  wire  pngu_pkg::nbr_t                     nbr,
    output pngu_pkg::byte_t                          raw_byte
);
    import pngu_pkg::*;

    logic [BYTE_W:0]   avg_sum;
    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_abc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    byte_t             paeth;
    byte_t             pred;

    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    always_comb
    begin
        avg_sum = {1'b0, nbr.left} + {1'b0, nbr.up};
        d_bc    = $signed({2'b00, nbr.up}) - $signed({2'b00, nbr.up_left});
        d_ac    = $signed({2'b00, nbr.left}) - $signed({2'b00, nbr.up_left});
        d_abc   = d_bc + d_ac;
        pa      = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
        pb      = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
        pc      = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

        if (pa <= pb && pa <= pc)
        begin
            paeth = nbr.left;
        end
        else if (pb <= pc)
        begin
            paeth = nbr.up;
        end
        else
        begin
            paeth = nbr.up_left;
        end

        case (filter_type)
            FT_SUB:     pred = nbr.left;
            FT_UP:      pred = nbr.up;
            FT_AVERAGE: pred = avg_sum[BYTE_W:1];
            FT_PAETH:   pred = paeth;
            default:    pred = '0;
        endcase

        raw_byte = filt_byte + pred;
    end

endmodule

`default_nettype wire

/* hw/rtl/png_scanline_unfilter.sv */
// png scanline unfilter top level: column control, prior row memory, output register
// flow: stage 1 register, then output register; one byte per cycle while the output
//   is ready; the prior row read is issued on the input transfer and a same-column
//   write at that same edge is forwarded around the memory
// reset: control, column count, config and the left windows clear at once;
//   the prior row memory is not cleared and reads as undefined until written
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = 4096,
    parameter int MAX_BPP       = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire  [pngu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [pngu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    pngu_in_if.sink                             filtered,
    pngu_out_if.source                          unfiltered
);
    import pngu_pkg::*;

    // column index width and width of the effective row length
    localparam int CNT_W = $clog2(MAX_ROW_BYTES);
    localparam int RBW   = ($clog2(MAX_ROW_BYTES + 1) > ROW_BYTES_W) ?
                           $clog2(MAX_ROW_BYTES + 1) : ROW_BYTES_W;

    // ---------------------------------------------------------------
    // configuration, stored already clamped to the legal range
    // ---------------------------------------------------------------
    logic [BPP_W-1:0]       bpp_reg;
    logic [BPP_W-1:0]       bpp_next;
    logic [RBW-1:0]         row_bytes_reg;
    logic [RBW-1:0]         row_bytes_next;
    logic [BPP_W-1:0]       cfg_bpp_val;
    logic [ROW_BYTES_W-1:0] cfg_rb_val;

    always_comb
    begin
        cfg_bpp_val    = cfg_wdata[BPP_W-1:0];
        cfg_rb_val     = cfg_wdata[ROW_BYTES_W-1:0];
        bpp_next       = bpp_reg;
        row_bytes_next = row_bytes_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BPP:
                begin
                    // zero acts as one, anything too large as the maximum
                    if (cfg_bpp_val == '0)
                        bpp_next = BPP_W'(1);
                    else if (int'(cfg_bpp_val) > MAX_BPP)
                        bpp_next = BPP_W'(MAX_BPP);
                    else
                        bpp_next = cfg_bpp_val;
                end
                REG_ROW_BYTES:
                begin
                    if (cfg_rb_val == '0)
                        row_bytes_next = RBW'(1);
                    else if (int'(cfg_rb_val) > MAX_ROW_BYTES)
                        row_bytes_next = RBW'(MAX_ROW_BYTES);
                    else
                        row_bytes_next = RBW'(cfg_rb_val);
                end
                default:
                begin
                    bpp_next = bpp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_W'(1);
            row_bytes_reg <= RBW'(1);
        end
        else
        begin
            bpp_reg       <= bpp_next;
            row_bytes_reg <= row_bytes_next;
        end
    end

    // ---------------------------------------------------------------
    // handshake: stage 1 moves whenever the output register can take it
    // ---------------------------------------------------------------
    logic  s1_valid_reg;
    logic  s1_valid_next;
    logic  s1_fire;
    logic  in_xfer;
    logic  out_valid_reg;
    logic  out_valid_next;

    assign s1_fire         = s1_valid_reg && (!out_valid_reg || unfiltered.ready);
    assign filtered.ready  = !s1_valid_reg || s1_fire;
    assign in_xfer         = filtered.valid && filtered.ready;

    // ---------------------------------------------------------------
    // column count, advanced on every input transfer
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [RBW-1:0]   count_plus1;
    logic             item_end;

    always_comb
    begin
        count_plus1 = RBW'(count_reg) + RBW'(1);
        // also catches a row length lowered below the current column
        item_end    = (count_plus1 >= row_bytes_reg);
        count_next  = count_reg;
        if (in_xfer)
        begin
            count_next = item_end ? '0 : count_plus1[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // ---------------------------------------------------------------
    // stage 1 payload, captured on the input transfer
    // ---------------------------------------------------------------
    byte_t                  s1_byte_reg;
    logic [FILT_TYPE_W-1:0] s1_ft_reg;
    logic                   s1_first_reg;
    logic [CNT_W-1:0]       s1_col_reg;
    logic                   s1_end_reg;
    logic                   s1_fwd_reg;
    byte_t                  s1_fwd_data_reg;
    logic                   fwd_next;
    byte_t                  raw;

    // the item in stage 1 writes its column at the same edge the new item reads
    assign fwd_next = s1_fire && (s1_col_reg == count_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg     <= filtered.filt_byte;
            s1_ft_reg       <= filtered.filter_type;
            s1_first_reg    <= filtered.first_row;
            s1_col_reg      <= count_reg;
            s1_end_reg      <= item_end;
            s1_fwd_reg      <= fwd_next;
            s1_fwd_data_reg <= raw;
        end
    end

    // ---------------------------------------------------------------
    // prior row memory
    // ---------------------------------------------------------------
    byte_t prior_rd;

    pngu_prior_ram #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (CNT_W)
    ) u_prior_ram (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (raw),
        .rd_en   (in_xfer),
        .rd_addr (count_reg),
        .rd_data (prior_rd)
    );

    // ---------------------------------------------------------------
    // left windows: last raw and prior bytes of the current row
    // ---------------------------------------------------------------
    byte_t                raw_win_reg   [WIN_DEPTH];
    byte_t                prior_win_reg [WIN_DEPTH];
    logic                 has_left;
    logic [WIN_IDX_W-1:0] left_idx;
    logic [WIN_IDX_W-1:0] wr_idx;
    nbr_t                 nbr;

    always_comb
    begin
        has_left = ({1'b0, s1_col_reg} >= (CNT_W + 1)'(bpp_reg));
        left_idx = s1_col_reg[WIN_IDX_W-1:0] - bpp_reg[WIN_IDX_W-1:0];
        wr_idx   = s1_col_reg[WIN_IDX_W-1:0];

        // missing neighbours read zero; no prior row on the first row
        nbr.up      = s1_first_reg ? '0 : (s1_fwd_reg ? s1_fwd_data_reg : prior_rd);
        nbr.left    = has_left ? raw_win_reg[left_idx] : '0;
        nbr.up_left = (has_left && !s1_first_reg) ? prior_win_reg[left_idx] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                raw_win_reg[i]   <= '0;
                prior_win_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            raw_win_reg[wr_idx]   <= raw;
            prior_win_reg[wr_idx] <= nbr.up;
        end
    end

    pngu_predictor u_predictor (
        .filt_byte   (s1_byte_reg),
        .filter_type (s1_ft_reg),
        .nbr         (nbr),
        .raw_byte    (raw)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    byte_t out_raw_reg;
    logic  out_end_reg;

    assign out_valid_next = s1_fire || (out_valid_reg && !unfiltered.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_raw_reg <= raw;
            out_end_reg <= s1_end_reg;
        end
    end

    assign unfiltered.valid    = out_valid_reg;
    assign unfiltered.raw_byte = out_raw_reg;
    assign unfiltered.row_end  = out_end_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a new transfer never lands on a stage 1 item that is not leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s1_valid_reg) |-> s1_fire)
        else $error("stage 1 item overwritten");

    // the last byte of a row restarts the column count
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && item_end) |=> (count_reg == '0 && s1_end_reg))
        else $error("column count not restarted at row end");

    // forwarding only applies when the previous item wrote the same column
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && fwd_next) |=> (s1_col_reg == $past(s1_col_reg)))
        else $error("forwarded byte from a different column");

    // the stored row length stays within range
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_bytes_reg != '0) && (int'(row_bytes_reg) <= MAX_ROW_BYTES))
        else $error("row length out of range");

endmodule

`default_nettype wire
